// File: sv/assert_macros.svh
// Assertion helpers for the boundary contact checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("boundary contact assertion failed");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("boundary contact assertion failed");

`endif

// File: sv/pbcn_pkg.sv
`timescale 1ns / 1ps
package pbcn_pkg;

    localparam int EDGE_SLOTS     = 16;
    localparam int ARC_SLOTS      = 32;
    localparam int NUM_EDGES_DEF  = 6;
    localparam int NUM_ARCS_DEF   = 12;

    localparam int RADIUS_W   = 13;
    localparam int POS_W      = 16;
    localparam int NORM_W     = 16;
    localparam int DIFF_W     = 17;
    localparam int D2_W       = 33;
    localparam int X25_W      = 38;
    localparam int RR_W       = 34;
    localparam int V_W        = D2_W + 17;
    localparam int ROOT_W     = (V_W + 1) / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int MAG_W      = 16;
    localparam int NUM_W      = MAG_W + 22 + 1;
    localparam int Q_W        = 15;

    localparam logic [Q_W-1:0]      ONE_Q14         = Q_W'(16384);
    localparam logic [RR_W-1:0]     RR12_RST        = 34'd37748736;
    localparam logic [RR_W-1:0]     RR13_RST        = 34'd44302336;

    typedef enum logic [2:0] {
        SIDE_NONE = 3'd0,
        SIDE_LT_X = 3'd1,
        SIDE_GT_X = 3'd2,
        SIDE_LT_Z = 3'd3,
        SIDE_GT_Z = 3'd4
    } side_t;

    typedef struct packed {
        side_t             side;
        logic signed [15:0] lo;
        logic signed [15:0] hi;
        logic signed [15:0] line;
        logic signed [15:0] nx;
        logic signed [15:0] nz;
    } edge_ent_t;

    typedef struct packed {
        logic               used;
        logic signed [15:0] cx;
        logic signed [15:0] cz;
        logic               k13;
    } arc_ent_t;

    typedef struct packed {
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  z;
        logic                     hit;
        logic                     arc;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] nz;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dz;
        logic [D2_W-1:0]          d2;
    } slot_t;

    typedef struct packed {
        logic                     hit;
        logic                     arc;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] nz;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dz;
        logic [V_W-1:0]           v;
        logic [REM_W-1:0]         rem;
        logic [ROOT_W-1:0]        root;
    } sqrt_t;

    typedef struct packed {
        logic                     hit;
        logic                     arc;
        logic signed [NORM_W-1:0] nx;
        logic signed [NORM_W-1:0] nz;
        logic                     sx;
        logic                     sz;
        logic [NUM_W-1:0]         remx;
        logic [NUM_W-1:0]         remz;
        logic [Q_W-1:0]           qx;
        logic [Q_W-1:0]           qz;
        logic [ROOT_W-1:0]        len;
    } quo_t;

    function automatic edge_ent_t edge_ent(input int i);
        edge_ent_t e;
        case (i)
            0: e = '{SIDE_LT_Z, -16'sd10175, 16'sd10175, -16'sd21887, 16'sd0, 16'sd16384};
            1: e = '{SIDE_LT_X, -16'sd21299, -16'sd1015, -16'sd10768, 16'sd16384, 16'sd0};
            2: e = '{SIDE_LT_X, 16'sd1015, 16'sd21299, -16'sd10768, 16'sd16384, 16'sd0};
            3: e = '{SIDE_GT_Z, -16'sd10175, 16'sd10175, 16'sd21887, 16'sd0, -16'sd16384};
            4: e = '{SIDE_GT_X, -16'sd21299, -16'sd1015, 16'sd10768, -16'sd16384, 16'sd0};
            5: e = '{SIDE_GT_X, 16'sd1015, 16'sd21299, 16'sd10768, -16'sd16384, 16'sd0};
            default: e = '{SIDE_NONE, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        endcase
        return e;
    endfunction

    function automatic arc_ent_t arc_ent(input int i);
        arc_ent_t a;
        case (i)
            0:  a = '{1'b1, -16'sd11807, -16'sd1015, 1'b0};
            1:  a = '{1'b1, -16'sd11807, 16'sd1015, 1'b0};
            2:  a = '{1'b1, 16'sd11807, -16'sd1015, 1'b0};
            3:  a = '{1'b1, 16'sd11807, 16'sd1015, 1'b0};
            4:  a = '{1'b1, 16'sd10240, 16'sd23003, 1'b1};
            5:  a = '{1'b1, 16'sd10240, -16'sd23003, 1'b1};
            6:  a = '{1'b1, -16'sd10240, 16'sd23003, 1'b1};
            7:  a = '{1'b1, -16'sd10240, -16'sd23003, 1'b1};
            8:  a = '{1'b1, 16'sd11878, 16'sd21430, 1'b1};
            9:  a = '{1'b1, -16'sd11878, 16'sd21430, 1'b1};
            10: a = '{1'b1, 16'sd11878, -16'sd21430, 1'b1};
            11: a = '{1'b1, -16'sd11878, -16'sd21430, 1'b1};
            default: a = '{1'b0, 16'sd0, 16'sd0, 1'b0};
        endcase
        return a;
    endfunction

endpackage

// File: sv/pbcn_slot_cell.sv
`timescale 1ns / 1ps
module pbcn_slot_cell #(
    parameter int SLOT      = 0,
    parameter int NUM_EDGES = pbcn_pkg::NUM_EDGES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  pbcn_pkg::slot_t              in_data,
    input  logic [pbcn_pkg::RR_W-1:0]    rr12,
    input  logic [pbcn_pkg::RR_W-1:0]    rr13,
    output logic                         out_valid,
    input  logic                         out_ready,
    output pbcn_pkg::slot_t              out_data
);

    localparam pbcn_pkg::edge_ent_t EDGE =
        pbcn_pkg::edge_ent((SLOT < NUM_EDGES) ? SLOT : -1);
    localparam pbcn_pkg::arc_ent_t ARC =
        pbcn_pkg::arc_ent((SLOT < NUM_EDGES) ? -1 : SLOT - NUM_EDGES);

    logic                               valid_reg;
    pbcn_pkg::slot_t                    data_reg;
    pbcn_pkg::slot_t                    data_next;
    logic                               adv;
    logic                               edge_hit;
    logic                               arc_hit;
    logic signed [pbcn_pkg::DIFF_W-1:0] dx;
    logic signed [pbcn_pkg::DIFF_W-1:0] dz;
    logic signed [2*pbcn_pkg::DIFF_W-1:0] sqx;
    logic signed [2*pbcn_pkg::DIFF_W-1:0] sqz;
    logic [pbcn_pkg::D2_W-1:0]          d2;
    logic [pbcn_pkg::X25_W-1:0]         d2x25;
    logic [pbcn_pkg::RR_W-1:0]          rr;

    always_comb begin
        case (EDGE.side)
            pbcn_pkg::SIDE_LT_X: edge_hit = in_data.z >= EDGE.lo && in_data.z <= EDGE.hi
                                            && in_data.x < EDGE.line;
            pbcn_pkg::SIDE_GT_X: edge_hit = in_data.z >= EDGE.lo && in_data.z <= EDGE.hi
                                            && in_data.x > EDGE.line;
            pbcn_pkg::SIDE_LT_Z: edge_hit = in_data.x >= EDGE.lo && in_data.x <= EDGE.hi
                                            && in_data.z < EDGE.line;
            pbcn_pkg::SIDE_GT_Z: edge_hit = in_data.x >= EDGE.lo && in_data.x <= EDGE.hi
                                            && in_data.z > EDGE.line;
            default:             edge_hit = 1'b0;
        endcase

        dx    = {in_data.x[15], in_data.x} - {ARC.cx[15], ARC.cx};
        dz    = {in_data.z[15], in_data.z} - {ARC.cz[15], ARC.cz};
        sqx   = dx * dx;
        sqz   = dz * dz;
        d2    = {1'b0, sqx[31:0]} + {1'b0, sqz[31:0]};
        d2x25 = {1'b0, d2, 4'b0} + {2'b0, d2, 3'b0} + {5'b0, d2};
        rr    = ARC.k13 ? rr13 : rr12;
        arc_hit = ARC.used && (d2x25 < {4'b0, rr});

        data_next = in_data;
        if (!in_data.hit) begin
            if (edge_hit) begin
                data_next.hit = 1'b1;
                data_next.nx  = EDGE.nx;
                data_next.nz  = EDGE.nz;
            end else if (arc_hit) begin
                data_next.hit = 1'b1;
                data_next.arc = 1'b1;
                data_next.dx  = dx;
                data_next.dz  = dz;
                data_next.d2  = d2;
            end
        end
    end

    assign adv       = !valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/pbcn_sqrt_cell.sv
`timescale 1ns / 1ps
module pbcn_sqrt_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  pbcn_pkg::sqrt_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output pbcn_pkg::sqrt_t out_data
);

    logic                          valid_reg;
    pbcn_pkg::sqrt_t               data_reg;
    pbcn_pkg::sqrt_t               data_next;
    logic                          adv;
    logic [pbcn_pkg::REM_W+1:0]    rem2;
    logic [pbcn_pkg::REM_W+1:0]    trial;

    always_comb begin
        rem2  = {in_data.rem, in_data.v[pbcn_pkg::V_W-1 -: 2]};
        trial = {2'b0, in_data.root, 2'b01};
        data_next   = in_data;
        data_next.v = {in_data.v[pbcn_pkg::V_W-3:0], 2'b00};
        if (rem2 >= trial) begin
            data_next.rem  = pbcn_pkg::REM_W'(rem2 - trial);
            data_next.root = {in_data.root[pbcn_pkg::ROOT_W-2:0], 1'b1};
        end else begin
            data_next.rem  = pbcn_pkg::REM_W'(rem2);
            data_next.root = {in_data.root[pbcn_pkg::ROOT_W-2:0], 1'b0};
        end
    end

    assign adv       = !valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/pbcn_div_cell.sv
`timescale 1ns / 1ps
module pbcn_div_cell #(
    parameter int BIT = 0
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  pbcn_pkg::quo_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output pbcn_pkg::quo_t out_data
);

    logic                       valid_reg;
    pbcn_pkg::quo_t             data_reg;
    pbcn_pkg::quo_t             data_next;
    logic                       adv;
    logic [pbcn_pkg::NUM_W-1:0] dsh;

    always_comb begin
        dsh       = pbcn_pkg::NUM_W'(in_data.len) << BIT;
        data_next = in_data;
        if (in_data.remx >= dsh) begin
            data_next.remx = in_data.remx - dsh;
            data_next.qx   = {in_data.qx[pbcn_pkg::Q_W-2:0], 1'b1};
        end else begin
            data_next.qx   = {in_data.qx[pbcn_pkg::Q_W-2:0], 1'b0};
        end
        if (in_data.remz >= dsh) begin
            data_next.remz = in_data.remz - dsh;
            data_next.qz   = {in_data.qz[pbcn_pkg::Q_W-2:0], 1'b1};
        end else begin
            data_next.qz   = {in_data.qz[pbcn_pkg::Q_W-2:0], 1'b0};
        end
    end

    assign adv       = !valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/point_boundary_contact_normal_core.sv
`timescale 1ns / 1ps
// Throughput: one transaction per cycle while m_ready keeps up; each cell stage holds one transaction.
// The chain is one slot cell per edge or arc, then the square root and divide cells.
// Stages stall individually, so bubbles collapse when the output is held.
// Reset (aresetn low, synchronous) empties all stages and sets the ball radius to 512.
module point_boundary_contact_normal_core #(
    parameter int NUM_EDGES = pbcn_pkg::NUM_EDGES_DEF,
    parameter int NUM_ARCS  = pbcn_pkg::NUM_ARCS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wen,
    input  logic [pbcn_pkg::RADIUS_W-1:0]     cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [pbcn_pkg::POS_W-1:0] s_pos_x,
    input  logic signed [pbcn_pkg::POS_W-1:0] s_pos_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_hit,
    output logic signed [pbcn_pkg::NORM_W-1:0] m_normal_x,
    output logic signed [pbcn_pkg::NORM_W-1:0] m_normal_z
);

    localparam int NS = NUM_EDGES + NUM_ARCS;
    localparam int SQ = pbcn_pkg::SQRT_STEPS;
    localparam int QS = pbcn_pkg::Q_W;

    logic [pbcn_pkg::RR_W-1:0]       rr12_reg, rr13_reg;
    logic [2*pbcn_pkg::RADIUS_W-1:0] rsq;

    pbcn_pkg::slot_t slot_d [0:NS];
    logic            slot_v [0:NS];
    logic            slot_r [0:NS];
    pbcn_pkg::sqrt_t sq_d   [0:SQ];
    logic            sq_v   [0:SQ];
    logic            sq_r   [0:SQ];
    pbcn_pkg::quo_t  qu_d   [0:QS];
    logic            qu_v   [0:QS];
    logic            qu_r   [0:QS];

    logic [pbcn_pkg::MAG_W-1:0]  magx, magz;
    logic [pbcn_pkg::DIFF_W-1:0] absx, absz;
    logic [pbcn_pkg::Q_W-1:0]    satx, satz;
    logic signed [pbcn_pkg::NORM_W-1:0] nx_fin, nz_fin;
    logic                        out_adv;
    logic                        m_valid_reg;
    logic                        m_hit_reg;
    logic signed [pbcn_pkg::NORM_W-1:0] m_normal_x_reg, m_normal_z_reg;

    // radius thresholds: 144 * r^2 and 169 * r^2
    assign rsq = cfg_wdata * cfg_wdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rr12_reg <= pbcn_pkg::RR12_RST;
            rr13_reg <= pbcn_pkg::RR13_RST;
        end else if (cfg_wen) begin
            rr12_reg <= (pbcn_pkg::RR_W'(rsq) << 7) + (pbcn_pkg::RR_W'(rsq) << 4);
            rr13_reg <= (pbcn_pkg::RR_W'(rsq) << 7) + (pbcn_pkg::RR_W'(rsq) << 5)
                      + (pbcn_pkg::RR_W'(rsq) << 3) + pbcn_pkg::RR_W'(rsq);
        end
    end

    always_comb begin
        slot_d[0]     = '0;
        slot_d[0].x   = s_pos_x;
        slot_d[0].z   = s_pos_z;
    end
    assign slot_v[0] = s_valid;
    assign s_ready   = slot_r[0];

    for (genvar i = 0; i < NS; i++) begin : g_slot
        pbcn_slot_cell #(
            .SLOT      (i),
            .NUM_EDGES (NUM_EDGES)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (slot_v[i]),
            .in_ready  (slot_r[i]),
            .in_data   (slot_d[i]),
            .rr12      (rr12_reg),
            .rr13      (rr13_reg),
            .out_valid (slot_v[i+1]),
            .out_ready (slot_r[i+1]),
            .out_data  (slot_d[i+1])
        );
    end

    always_comb begin
        sq_d[0].hit  = slot_d[NS].hit;
        sq_d[0].arc  = slot_d[NS].arc;
        sq_d[0].nx   = slot_d[NS].nx;
        sq_d[0].nz   = slot_d[NS].nz;
        sq_d[0].dx   = slot_d[NS].dx;
        sq_d[0].dz   = slot_d[NS].dz;
        sq_d[0].v    = {1'b0, slot_d[NS].d2, 16'b0};
        sq_d[0].rem  = '0;
        sq_d[0].root = '0;
    end
    assign sq_v[0]    = slot_v[NS];
    assign slot_r[NS] = sq_r[0];

    for (genvar i = 0; i < SQ; i++) begin : g_sqrt
        pbcn_sqrt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (sq_v[i]),
            .in_ready  (sq_r[i]),
            .in_data   (sq_d[i]),
            .out_valid (sq_v[i+1]),
            .out_ready (sq_r[i+1]),
            .out_data  (sq_d[i+1])
        );
    end

    always_comb begin
        absx = sq_d[SQ].dx[pbcn_pkg::DIFF_W-1] ? -sq_d[SQ].dx : sq_d[SQ].dx;
        absz = sq_d[SQ].dz[pbcn_pkg::DIFF_W-1] ? -sq_d[SQ].dz : sq_d[SQ].dz;
        magx = absx[pbcn_pkg::MAG_W-1:0];
        magz = absz[pbcn_pkg::MAG_W-1:0];
        qu_d[0].hit  = sq_d[SQ].hit;
        qu_d[0].arc  = sq_d[SQ].arc;
        qu_d[0].nx   = sq_d[SQ].nx;
        qu_d[0].nz   = sq_d[SQ].nz;
        qu_d[0].sx   = sq_d[SQ].dx[pbcn_pkg::DIFF_W-1];
        qu_d[0].sz   = sq_d[SQ].dz[pbcn_pkg::DIFF_W-1];
        qu_d[0].remx = pbcn_pkg::NUM_W'({magx, 22'b0})
                     + pbcn_pkg::NUM_W'(sq_d[SQ].root >> 1);
        qu_d[0].remz = pbcn_pkg::NUM_W'({magz, 22'b0})
                     + pbcn_pkg::NUM_W'(sq_d[SQ].root >> 1);
        qu_d[0].qx   = '0;
        qu_d[0].qz   = '0;
        qu_d[0].len  = sq_d[SQ].root;
    end
    assign qu_v[0]  = sq_v[SQ];
    assign sq_r[SQ] = qu_r[0];

    for (genvar i = 0; i < QS; i++) begin : g_div
        pbcn_div_cell #(
            .BIT (QS - 1 - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (qu_v[i]),
            .in_ready  (qu_r[i]),
            .in_data   (qu_d[i]),
            .out_valid (qu_v[i+1]),
            .out_ready (qu_r[i+1]),
            .out_data  (qu_d[i+1])
        );
    end

    always_comb begin
        satx = (qu_d[QS].qx > pbcn_pkg::ONE_Q14) ? pbcn_pkg::ONE_Q14 : qu_d[QS].qx;
        satz = (qu_d[QS].qz > pbcn_pkg::ONE_Q14) ? pbcn_pkg::ONE_Q14 : qu_d[QS].qz;
        if (!qu_d[QS].arc) begin
            nx_fin = qu_d[QS].nx;
            nz_fin = qu_d[QS].nz;
        end else if (qu_d[QS].len == '0) begin
            nx_fin = '0;
            nz_fin = '0;
        end else begin
            nx_fin = qu_d[QS].sx ? -$signed({1'b0, satx}) : $signed({1'b0, satx});
            nz_fin = qu_d[QS].sz ? -$signed({1'b0, satz}) : $signed({1'b0, satz});
        end
    end

    assign out_adv  = !m_valid_reg || m_ready;
    assign qu_r[QS] = out_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_adv) begin
            m_valid_reg <= qu_v[QS];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv) begin
            m_hit_reg      <= qu_d[QS].hit;
            m_normal_x_reg <= nx_fin;
            m_normal_z_reg <= nz_fin;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_hit      = m_hit_reg;
    assign m_normal_x = m_normal_x_reg;
    assign m_normal_z = m_normal_z_reg;

endmodule

// File: sv/pbcn_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pbcn_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic                               m_hit,
    input logic signed [pbcn_pkg::NORM_W-1:0] m_normal_x,
    input logic signed [pbcn_pkg::NORM_W-1:0] m_normal_z
);

    // a miss carries no normal
    `ASSERT_IMP(a_miss_zero, aclk, aresetn, m_valid && !m_hit, m_normal_x == 0 && m_normal_z == 0)

    // normals stay within one unit in Q1.14
    `ASSERT_IMP(a_norm_range, aclk, aresetn, m_valid, m_normal_x >= -16'sd16384 && m_normal_x <= 16'sd16384 && m_normal_z >= -16'sd16384 && m_normal_z <= 16'sd16384)

    // held transaction keeps its payload
    `ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_hit) && $stable(m_normal_x) && $stable(m_normal_z))

endmodule

bind point_boundary_contact_normal_core pbcn_checker u_pbcn_checker (.*);

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;

    localparam int HOLD_CYCLES  = 250;
    localparam int DRAIN_CYCLES = 70;
    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 100;

    localparam pbcn_pkg::side_t EDGE_SIDE[6] = '{pbcn_pkg::SIDE_LT_Z, pbcn_pkg::SIDE_LT_X,
                                                 pbcn_pkg::SIDE_LT_X, pbcn_pkg::SIDE_GT_Z,
                                                 pbcn_pkg::SIDE_GT_X, pbcn_pkg::SIDE_GT_X};
    localparam int EDGE_LO[6]   = '{-10175, -21299, 1015, -10175, -21299, 1015};
    localparam int EDGE_HI[6]   = '{10175, -1015, 21299, 10175, -1015, 21299};
    localparam int EDGE_LINE[6] = '{-21887, -10768, -10768, 21887, 10768, 10768};
    localparam int EDGE_NX[6]   = '{0, 16384, 16384, 0, -16384, -16384};
    localparam int EDGE_NZ[6]   = '{16384, 0, 0, -16384, 0, 0};
    localparam int ARC_CX[12] = '{-11807, -11807, 11807, 11807, 10240, 10240,
                                  -10240, -10240, 11878, -11878, 11878, -11878};
    localparam int ARC_CZ[12] = '{-1015, 1015, -1015, 1015, 23003, -23003,
                                  23003, -23003, 21430, 21430, -21430, -21430};
    localparam int ARC_K[12]  = '{12, 12, 12, 12, 13, 13, 13, 13, 13, 13, 13, 13};

    typedef struct {
        logic                               hit;
        logic signed [pbcn_pkg::NORM_W-1:0] nx;
        logic signed [pbcn_pkg::NORM_W-1:0] nz;
    } contact_t;

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic signed [pbcn_pkg::NORM_W-1:0] unit_comp(longint off,
                                                                     longint unsigned len);
        longint unsigned mag;
        longint unsigned q;
        if (len == 0) return '0;
        mag = (off < 0) ? longint'(-off) : longint'(off);
        q = ((mag << 22) + (len >> 1)) / len;
        if (q > 16384) q = 16384;
        return (off < 0) ? -pbcn_pkg::NORM_W'(q) : pbcn_pkg::NORM_W'(q);
    endfunction

    function automatic contact_t contact_normal(int x, int z, int unsigned radius);
        contact_t c;
        bit inspan;
        bit beyond;
        longint dx;
        longint dz;
        longint unsigned d2;
        longint unsigned rr;
        longint unsigned len;
        c = '{1'b0, '0, '0};
        for (int i = 0; i < 6; i++) begin
            case (EDGE_SIDE[i])
                pbcn_pkg::SIDE_LT_X: begin
                    inspan = z >= EDGE_LO[i] && z <= EDGE_HI[i];
                    beyond = x < EDGE_LINE[i];
                end
                pbcn_pkg::SIDE_GT_X: begin
                    inspan = z >= EDGE_LO[i] && z <= EDGE_HI[i];
                    beyond = x > EDGE_LINE[i];
                end
                pbcn_pkg::SIDE_LT_Z: begin
                    inspan = x >= EDGE_LO[i] && x <= EDGE_HI[i];
                    beyond = z < EDGE_LINE[i];
                end
                default: begin
                    inspan = x >= EDGE_LO[i] && x <= EDGE_HI[i];
                    beyond = z > EDGE_LINE[i];
                end
            endcase
            if (inspan && beyond) begin
                c.hit = 1'b1;
                c.nx = pbcn_pkg::NORM_W'(EDGE_NX[i]);
                c.nz = pbcn_pkg::NORM_W'(EDGE_NZ[i]);
                return c;
            end
        end
        for (int i = 0; i < 12; i++) begin
            dx = longint'(x) - ARC_CX[i];
            dz = longint'(z) - ARC_CZ[i];
            d2 = longint'(dx * dx + dz * dz);
            rr = longint'(ARC_K[i] * ARC_K[i]) * radius * radius;
            if (25 * d2 < rr) begin
                len = floor_root(d2 << 16);
                c.hit = 1'b1;
                c.nx = unit_comp(dx, len);
                c.nz = unit_comp(dz, len);
                return c;
            end
        end
        return c;
    endfunction

    class contact_scoreboard;
        contact_t    pending[$];
        int unsigned radius = 512;
        int          errors = 0;

        function void note_input(logic signed [pbcn_pkg::POS_W-1:0] x,
                                 logic signed [pbcn_pkg::POS_W-1:0] z);
            pending.push_back(contact_normal(int'(x), int'(z), radius));
        endfunction

        function void check_result(logic hit, logic signed [pbcn_pkg::NORM_W-1:0] nx,
                                   logic signed [pbcn_pkg::NORM_W-1:0] nz);
            contact_t e;
            if (pending.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (hit !== e.hit) begin
                $error("hit: expected %0d, actual %0d", e.hit, hit);
                errors++;
            end
            if (nx !== e.nx) begin
                $error("normal_x: expected %0d, actual %0d", e.nx, nx);
                errors++;
            end
            if (nz !== e.nz) begin
                $error("normal_z: expected %0d, actual %0d", e.nz, nz);
                errors++;
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic cfg_wen = 0;
    logic [pbcn_pkg::RADIUS_W-1:0] cfg_wdata = '0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [pbcn_pkg::POS_W-1:0] s_pos_x = '0;
    logic signed [pbcn_pkg::POS_W-1:0] s_pos_z = '0;
    logic m_valid;
    logic m_ready = 1;
    logic m_hit;
    logic signed [pbcn_pkg::NORM_W-1:0] m_normal_x;
    logic signed [pbcn_pkg::NORM_W-1:0] m_normal_z;

    contact_scoreboard sb = new();
    bit idle_on = 1;
    bit hold_req = 0;
    int quiet_cycles = 0;

    always #5 aclk = ~aclk;

    point_boundary_contact_normal_core DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_pos_x(s_pos_x), .s_pos_z(s_pos_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_hit(m_hit),
        .m_normal_x(m_normal_x), .m_normal_z(m_normal_z)
    );

    // result side: check and random back-pressure
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) sb.check_result(m_hit, m_normal_x, m_normal_z);
            if (hold_req) begin
                hold_req = 0;
                stall = HOLD_CYCLES;
            end else if (stall == 0 && idle_on && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 6);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_point(int x, int z);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pos_x <= pbcn_pkg::POS_W'(x);
        s_pos_z <= pbcn_pkg::POS_W'(z);
        do @(posedge aclk); while (!s_ready);
        sb.note_input(s_pos_x, s_pos_z);
    endtask

    task automatic write_radius(int unsigned r);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= pbcn_pkg::RADIUS_W'(r);
        @(posedge aclk);
        cfg_wen <= 1'b0;
        sb.radius = r;
    endtask

    task automatic send_random(int unsigned r);
        int mode;
        int i;
        int span;
        int along;
        int across;
        mode = $urandom_range(0, 9);
        if (mode < 3) begin
            send_point($urandom_range(0, 65535), $urandom_range(0, 65535));
        end else if (mode < 7) begin
            i = $urandom_range(0, 11);
            span = (3 * r) + 2;
            send_point(ARC_CX[i] + $urandom_range(0, 2 * span) - span,
                       ARC_CZ[i] + $urandom_range(0, 2 * span) - span);
        end else begin
            i = $urandom_range(0, 5);
            along = EDGE_LO[i] - 64 + $urandom_range(0, EDGE_HI[i] - EDGE_LO[i] + 128);
            across = EDGE_LINE[i] + $urandom_range(0, 600) - 300;
            if (EDGE_SIDE[i] == pbcn_pkg::SIDE_LT_X || EDGE_SIDE[i] == pbcn_pkg::SIDE_GT_X)
                send_point(across, along);
            else
                send_point(along, across);
        end
    endtask

    initial begin
        int unsigned radii[7];
        radii = '{0, 8191, 4096, 1, 300, 700, 512};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_point(32767, 32767);
        send_point(-32768, -32768);
        send_point(32767, -32768);
        send_point(-32768, 32767);
        send_point(0, 0);
        for (int i = 0; i < 12; i++) send_point(ARC_CX[i], ARC_CZ[i]);
        send_point(10175, -21888);
        send_point(10176, -21888);
        send_point(0, -21887);
        send_point(-10769, -1015);
        send_point(10769, 1015);
        send_point(0, 21888);

        for (int p = 0; p < 7; p++) begin
            write_radius(radii[p]);
            if (p == 2) hold_req = 1;
            if (p == 6) idle_on = 0;
            if (p == 4) radii[p] = $urandom_range(1, 8191);
            if (p == 4) write_radius(radii[p]);
            for (int n = 0; n < PHASE_ITEMS; n++) send_random(radii[p]);
        end

        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
